// ===== src/skht_pkg.sv =====
// ----------------------------------------------------------------------------
// skht_pkg: shared types, constants and the prime table
// Constants, command and status codes, and the prime table used by the
// string-key hash table with linear probing.
// ----------------------------------------------------------------------------
package skht_pkg;

  localparam int TableDepth = 256;
  localparam int KeyBytes   = 8;
  localparam int ValueBits  = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int SizeW      = 9;
  localparam int LenW       = 4;
  localparam int KeyW       = 64;
  localparam int HashW      = 64;
  localparam int PrimeCount = 26;
  localparam logic [SizeW-1:0] SizeReset = 9'd256;

  localparam logic [1:0] CmdSet   = 2'd0;
  localparam logic [1:0] CmdGet   = 2'd1;
  localparam logic [1:0] CmdSlot  = 2'd2;
  localparam logic [1:0] CmdClear = 2'd3;

  localparam logic [1:0] StDone   = 2'd0;
  localparam logic [1:0] StAbsent = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;

  // Entry word: key, length, value.
  localparam int EntryW = KeyW + LenW + ValueBits;

  function automatic logic [31:0] prime_of(input logic [7:0] c);
    logic [7:0] m;
    logic [4:0] r;
    // Residue modulo 26 by compare and subtract of 208, 104, 52 and 26.
    m = c;
    if (m >= 8'd208) m = m - 8'd208;
    if (m >= 8'd104) m = m - 8'd104;
    if (m >= 8'd52)  m = m - 8'd52;
    if (m >= 8'd26)  m = m - 8'd26;
    r = m[4:0];
    case (r)
      5'd0:  prime_of = 32'd53;
      5'd1:  prime_of = 32'd97;
      5'd2:  prime_of = 32'd193;
      5'd3:  prime_of = 32'd389;
      5'd4:  prime_of = 32'd769;
      5'd5:  prime_of = 32'd1543;
      5'd6:  prime_of = 32'd3079;
      5'd7:  prime_of = 32'd6151;
      5'd8:  prime_of = 32'd12289;
      5'd9:  prime_of = 32'd24593;
      5'd10: prime_of = 32'd49157;
      5'd11: prime_of = 32'd98317;
      5'd12: prime_of = 32'd196613;
      5'd13: prime_of = 32'd393241;
      5'd14: prime_of = 32'd786433;
      5'd15: prime_of = 32'd1572869;
      5'd16: prime_of = 32'd3145739;
      5'd17: prime_of = 32'd6291469;
      5'd18: prime_of = 32'd12582917;
      5'd19: prime_of = 32'd25165843;
      5'd20: prime_of = 32'd50331653;
      5'd21: prime_of = 32'd100663319;
      5'd22: prime_of = 32'd201326611;
      5'd23: prime_of = 32'd402653189;
      5'd24: prime_of = 32'd805306457;
      5'd25: prime_of = 32'd1610612741;
      default: prime_of = 32'd53;
    endcase
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture request, clear hash
    logic hash_mul;    // low product step
    logic hash_hi;     // high product step and add
    logic mod_init;    // start remainder
    logic mod_step;    // one remainder bit
    logic probe_init;  // pos <= remainder, count <= 0
    logic probe_adv;   // pos++, count++
    logic rd;          // issue table read
    logic wr_set;      // store at pos
    logic wr_clr;      // free pos
    logic res_load;    // capture result
    logic [1:0] res_status;
    logic res_hit;     // result uses match data
  } skht_cmd_t;

  typedef struct packed {
    logic hash_done;   // all characters consumed
    logic used;        // used bit at pos
    logic match;       // registered entry matches
    logic walked;      // count reached table size
    logic [1:0] cmd;
  } skht_stat_t;

endpackage

// ===== src/skht_ram.sv =====
// ----------------------------------------------------------------------------
// skht_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module skht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/skht_datapath.sv =====
// ----------------------------------------------------------------------------
// skht_datapath: hash, remainder, probe walk and table storage
// Holds the request, the hash unit, the bit-serial remainder, the entry RAM
// and the used bits.
// ----------------------------------------------------------------------------
module skht_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  skht_pkg::skht_cmd_t      cmd_i,
  output skht_pkg::skht_stat_t     stat_o,
  input  logic [1:0]               req_cmd_i,
  input  logic [63:0]              req_key_i,
  input  logic [3:0]               req_len_i,
  input  logic [63:0]              req_value_i,
  input  logic [skht_pkg::SizeW-1:0] size_i,
  input  logic                     clear_all_i,
  output logic [1:0]               status_o,
  output logic [63:0]              value_o,
  output logic [7:0]               slot_index_o,
  output logic                     slot_valid_o
);
  import skht_pkg::*;

  logic [1:0]        cmd_q;
  logic [KeyW-1:0]   key_q;
  logic [LenW-1:0]   len_q;
  logic [ValueBits-1:0] val_q;
  logic [HashW-1:0]  h_q;
  logic [LenW-1:0]   ci_q;
  logic [63:0]       plo_q;
  logic [7:0]        c_q;
  logic [SizeW-1:0]  rem_q;
  logic [6:0]        mbit_q;
  logic [IdxW-1:0]   pos_q;
  logic [SizeW-1:0]  cnt_q;
  logic [TableDepth-1:0] used_q;
  logic              used_rd_q;
  logic [EntryW-1:0] rdata;
  logic [LenW-1:0]   len_c;
  logic [KeyW-1:0]   key_c;
  logic [7:0]        ch;
  logic [31:0]       pr;
  logic [SizeW:0]    rsh;
  logic [SizeW-1:0]  pos_inc;

  // Clamp length and mask bytes past it.
  always_comb begin
    len_c = (req_len_i > LenW'(KeyBytes)) ? LenW'(KeyBytes) : req_len_i;
    key_c = '0;
    for (int b = 0; b < KeyBytes; b++) begin
      if (LenW'(b) < len_c) key_c[8*b +: 8] = req_key_i[8*b +: 8];
    end
  end

  assign ch  = key_q[{ci_q[2:0], 3'b000} +: 8];
  assign pr  = prime_of(ch);
  assign rsh = {rem_q, h_q[mbit_q[5:0]]};
  assign pos_inc = SizeW'(pos_q) + 9'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= req_cmd_i;
      key_q <= key_c;
      len_q <= len_c;
      val_q <= req_value_i[ValueBits-1:0];
      h_q   <= '0;
      ci_q  <= '0;
    end
    // h*p split in two 32x32 products, each registered.
    if (cmd_i.hash_mul) begin
      plo_q <= h_q[31:0] * pr;
      c_q   <= ch;
    end
    if (cmd_i.hash_hi) begin
      h_q  <= plo_q + {h_q[63:32] * prime_of(c_q), 32'd0} + {56'd0, c_q};
      ci_q <= ci_q + 4'd1;
    end
    if (cmd_i.mod_init) begin
      rem_q  <= '0;
      mbit_q <= 7'd63;
    end
    if (cmd_i.mod_step) begin
      rem_q  <= (rsh >= {1'b0, size_i}) ? SizeW'(rsh - {1'b0, size_i}) : rsh[SizeW-1:0];
      mbit_q <= mbit_q - 7'd1;
    end
    if (cmd_i.probe_init) begin
      pos_q <= rem_q[IdxW-1:0];
      cnt_q <= '0;
    end
    if (cmd_i.probe_adv) begin
      pos_q <= (pos_inc >= size_i) ? '0 : pos_q + 8'd1;
      cnt_q <= cnt_q + 9'd1;
    end
    if (cmd_i.rd) used_rd_q <= used_q[pos_q];
    if (cmd_i.res_load) begin
      status_o     <= cmd_i.res_status;
      value_o      <= (cmd_i.res_hit && cmd_q == CmdGet) ?
                      64'(rdata[ValueBits-1:0]) : 64'd0;
      slot_valid_o <= (cmd_q == CmdSlot) && (cmd_i.res_status != StFull);
      slot_index_o <= (cmd_q == CmdSlot && cmd_i.res_status != StFull) ? pos_q : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (clear_all_i) begin
      used_q <= '0;
    end else if (cmd_i.wr_set) begin
      used_q[pos_q] <= 1'b1;
    end else if (cmd_i.wr_clr) begin
      used_q[pos_q] <= 1'b0;
    end
  end

  skht_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_set),
    .addr_i (pos_q),
    .wdata_i({key_q, len_q, val_q}),
    .rdata_o(rdata)
  );

  assign stat_o.hash_done = (ci_q == len_q);
  assign stat_o.used      = used_rd_q;
  assign stat_o.match     = used_rd_q && rdata[EntryW-1 -: KeyW] == key_q &&
                            rdata[ValueBits +: LenW] == len_q;
  assign stat_o.walked    = (cnt_q == size_i);
  assign stat_o.cmd       = cmd_q;
endmodule

// ===== src/skht_ctrl.sv =====
// ----------------------------------------------------------------------------
// skht_ctrl: request sequencer
// Steps through hashing, the remainder and the probe walk, and drives the
// handshakes.
// ----------------------------------------------------------------------------
module skht_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output skht_pkg::skht_cmd_t  cmd_o,
  input  skht_pkg::skht_stat_t stat_i
);
  import skht_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SHash  = 3'd1;
  localparam logic [2:0] SHashH = 3'd2;
  localparam logic [2:0] SMod   = 3'd3;
  localparam logic [2:0] SRead  = 3'd4;
  localparam logic [2:0] SCheck = 3'd5;
  localparam logic [2:0] SOut   = 3'd6;
  localparam logic [2:0] SInit  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [5:0] mcnt_q;
  logic       ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == SIdle) && !ovalid_q;
  assign out_valid_o = ovalid_q;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    ovalid_d = ovalid_q && !out_ready_i;
    case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = SHash;
        end
      end
      SHash: begin
        if (stat_i.hash_done) begin
          cmd_o.mod_init = 1'b1;
          state_d        = SMod;
        end else begin
          cmd_o.hash_mul = 1'b1;
          state_d        = SHashH;
        end
      end
      SHashH: begin
        cmd_o.hash_hi = 1'b1;
        state_d       = SHash;
      end
      SMod: begin
        cmd_o.mod_step = 1'b1;
        if (mcnt_q == 6'd63) state_d = SInit;
      end
      SInit: begin
        cmd_o.probe_init = 1'b1;
        state_d          = SRead;
      end
      SRead: begin
        cmd_o.rd = 1'b1;
        state_d  = SCheck;
      end
      SCheck: begin
        state_d = SOut;
        cmd_o.res_load = 1'b1;
        if (stat_i.walked) begin
          cmd_o.res_status = StFull;
        end else if (stat_i.cmd == CmdSet && (stat_i.match || !stat_i.used)) begin
          cmd_o.wr_set     = 1'b1;
          cmd_o.res_status = StDone;
        end else if (stat_i.cmd != CmdSet && !stat_i.used) begin
          cmd_o.res_status = StAbsent;
        end else if (stat_i.cmd != CmdSet && stat_i.match) begin
          cmd_o.res_status = StDone;
          cmd_o.res_hit    = 1'b1;
          cmd_o.wr_clr     = (stat_i.cmd == CmdClear);
        end else begin
          cmd_o.res_load  = 1'b0;
          cmd_o.probe_adv = 1'b1;
          state_d         = SRead;
        end
      end
      SOut: begin
        ovalid_d = 1'b1;
        state_d  = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      mcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      mcnt_q   <= (state_q == SMod) ? mcnt_q + 6'd1 : '0;
    end
  end
endmodule

// ===== src/string_key_hash_table_linear_probe.sv =====
// ----------------------------------------------------------------------------
// string_key_hash_table_linear_probe: key-value table with linear probing
// Hashes a key of up to eight characters, reduces it modulo the table size
// and walks the slots from there to set, get, locate or clear an entry.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in       sink       in_valid/in_ready   cmd, key_bytes, key_length, value_in
//  out      source     out_valid/out_ready status, value_out, slot_index, slot_valid
//  cfg      APB        psel/penable/pready table_size at address 0
//
// After the request transfer, the block hashes the key character by character
// (a 64-bit product split into two 32x32 multiplies), reduces the hash by a
// bit-serial remainder, loads the probe position, reads each probed slot
// through the registered RAM read, and then presents the result. The
// request channel stays closed until the result transfer has completed.
// Reset frees every slot at once through the used-bit flip-flops, and so
// does a write to table_size; no clearing pass.
module string_key_hash_table_linear_probe (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] key_bytes_i,
  input  logic [3:0]  key_length_i,
  input  logic [63:0] value_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] value_out_o,
  output logic [7:0]  slot_index_o,
  output logic        slot_valid_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import skht_pkg::*;

  skht_cmd_t        cmd;
  skht_stat_t       stat;
  logic [SizeW-1:0] size_q;
  logic             cfg_wr;
  logic [SizeW-1:0] wsize;

  assign pready = 1'b1;
  // Only one register, so paddr has no decoded bits beyond zero.
  assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);
  assign prdata = {23'd0, size_q};

  // Clamp the written size into 1..TableDepth.
  always_comb begin
    wsize = pwdata[SizeW-1:0];
    if (wsize == '0) wsize = SizeW'(1);
    if (wsize > SizeW'(TableDepth)) wsize = SizeW'(TableDepth);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_wr) begin
      size_q <= wsize;
    end
  end

  skht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  skht_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_cmd_i   (cmd_i),
    .req_key_i   (key_bytes_i),
    .req_len_i   (key_length_i),
    .req_value_i (value_in_i),
    .size_i      (size_q),
    .clear_all_i (cfg_wr),
    .status_o    (status_o),
    .value_o     (value_out_o),
    .slot_index_o(slot_index_o),
    .slot_valid_o(slot_valid_o)
  );
endmodule

// ===== src/skht_checker.sv =====
// ----------------------------------------------------------------------------
// skht_checker: port-level checks
// Observes the top-level ports only.
// ----------------------------------------------------------------------------
module skht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [63:0] value_out_o
);
  import skht_pkg::*;

  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request taken while result pending");

  a_accept_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("result right after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(status_o))
    else $error("result dropped");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StDone || status_o == StAbsent || status_o == StFull))
    else $error("bad status");

  a_value_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StDone) |-> value_out_o == 64'd0)
    else $error("value on miss");
endmodule

bind string_key_hash_table_linear_probe skht_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .status_o(status_o),
  .value_out_o(value_out_o)
);
